// ===== sv/ppp_pkg.sv =====
package ppp_pkg;

    localparam int ROT_W     = 16;
    localparam int Q_FRAC    = 14;
    localparam int T_W       = 20;
    localparam int F_W       = 20;
    localparam int PITCH_W   = 16;
    localparam int SIZE_W    = 12;
    localparam int OUT_W     = 32;
    localparam int CFG_W     = 60;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROT0  = 3'd0,
        REG_ROT1  = 3'd1,
        REG_ROT2  = 3'd2,
        REG_TRANS = 3'd3,
        REG_FOCAL = 3'd4,
        REG_PITCH = 3'd5,
        REG_SIZE  = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [2:0][3*ROT_W-1:0] rot;
        logic [3*T_W-1:0]        trans;
        logic [F_W-1:0]          focal;
        logic [2*PITCH_W-1:0]    pitch;
        logic [2*SIZE_W-1:0]     size;
    } t_cfg;

    localparam logic [3*ROT_W-1:0]     ROT0_RST  = 48'd16384;
    localparam logic [3*ROT_W-1:0]     ROT1_RST  = 48'd1073741824;
    localparam logic [3*ROT_W-1:0]     ROT2_RST  = 48'd70368744177664;
    localparam logic [3*T_W-1:0]       TRANS_RST = '0;
    localparam logic [F_W-1:0]         FOCAL_RST = 20'd256000;
    localparam logic [2*PITCH_W-1:0]   PITCH_RST = 32'd16777472;
    localparam logic [2*SIZE_W-1:0]    SIZE_RST  = 24'd2097664;

endpackage

// ===== sv/ppp_div.sv =====
module ppp_div #(
    parameter int N_W   = 49,
    parameter int D_W   = 29,
    parameter int LANES = 2,
    parameter int SB_W  = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    output logic                          o_rdy,
    input  logic [LANES-1:0][N_W-1:0]     i_num,
    input  logic [LANES-1:0][D_W-1:0]     i_den,
    input  logic [SB_W-1:0]               i_sb,
    output logic                          o_vld,
    input  logic                          i_rdy,
    output logic [LANES-1:0][N_W-1:0]     o_quo,
    output logic [LANES-1:0][D_W-1:0]     o_rem,
    output logic [SB_W-1:0]               o_sb
);

    // restoring divider, one quotient bit per stage, msb first
    logic [N_W-1:0] r_vld;
    logic [N_W:0]   w_rdy;

    logic [LANES-1:0][N_W-1:0] r_nq  [N_W];
    logic [LANES-1:0][D_W-1:0] r_rem [N_W];
    logic [LANES-1:0][D_W-1:0] r_den [N_W];
    logic [SB_W-1:0]           r_sb  [N_W];

    always_comb begin
        w_rdy[N_W] = i_rdy;
        for (int k = N_W - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    for (genvar k = 0; k < N_W; k++) begin : g_stg
        logic                      vld_in;
        logic [LANES-1:0][N_W-1:0] nq_in;
        logic [LANES-1:0][D_W-1:0] rem_in;
        logic [LANES-1:0][D_W-1:0] den_in;
        logic [SB_W-1:0]           sb_in;
        logic [LANES-1:0][N_W-1:0] n_nq;
        logic [LANES-1:0][D_W-1:0] n_rem;
        logic [D_W:0]              trial;
        logic                      ge;

        if (k == 0) begin : g_first
            assign vld_in = i_vld;
            assign nq_in  = i_num;
            assign rem_in = '0;
            assign den_in = i_den;
            assign sb_in  = i_sb;
        end else begin : g_next
            assign vld_in = r_vld[k-1];
            assign nq_in  = r_nq[k-1];
            assign rem_in = r_rem[k-1];
            assign den_in = r_den[k-1];
            assign sb_in  = r_sb[k-1];
        end

        always_comb begin
            trial = '0;
            ge    = 1'b0;
            for (int l = 0; l < LANES; l++) begin
                trial    = {rem_in[l], nq_in[l][N_W-1]};
                ge       = trial >= {1'b0, den_in[l]};
                n_rem[l] = ge ? D_W'(trial - {1'b0, den_in[l]}) : trial[D_W-1:0];
                n_nq[l]  = {nq_in[l][N_W-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (w_rdy[k]) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[k]) begin
                r_nq[k]  <= n_nq;
                r_rem[k] <= n_rem;
                r_den[k] <= den_in;
                r_sb[k]  <= sb_in;
            end
        end
    end

    assign o_rdy = w_rdy[0];
    assign o_vld = r_vld[N_W-1];
    assign o_quo = r_nq[N_W-1];
    assign o_rem = r_rem[N_W-1];
    assign o_sb  = r_sb[N_W-1];

endmodule

// ===== sv/ppp_xform.sv =====
module ppp_xform #(
    parameter int P_W = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ppp_pkg::t_cfg          i_cfg,
    input  logic                   i_vld,
    output logic                   o_rdy,
    input  logic signed [P_W-1:0]  i_px,
    input  logic signed [P_W-1:0]  i_py,
    input  logic signed [P_W-1:0]  i_pz,
    output logic                   o_vld,
    input  logic                   i_rdy,
    output logic signed [P_W+4:0]  o_xc,
    output logic signed [P_W+4:0]  o_yc,
    output logic signed [P_W+4:0]  o_zc
);
    import ppp_pkg::*;

    localparam int PR_W  = P_W + ROT_W;
    localparam int SUM_W = PR_W + 2;
    localparam int CAM_W = P_W + 5;

    logic [2:0] r_vld;
    logic [3:0] w_rdy;

    logic signed [ROT_W-1:0] w_rot [3][3];
    logic signed [P_W-1:0]   w_p   [3];
    logic signed [T_W-1:0]   w_t   [3];

    logic signed [PR_W-1:0]  r_prod [3][3];
    logic signed [SUM_W-1:0] r_sum  [3];
    logic signed [CAM_W-1:0] r_cam  [3];

    always_comb begin
        w_p[0] = i_px;
        w_p[1] = i_py;
        w_p[2] = i_pz;
        for (int r = 0; r < 3; r++) begin
            w_t[r] = i_cfg.trans[r*T_W +: T_W];
            for (int c = 0; c < 3; c++) begin
                w_rot[r][c] = i_cfg.rot[r][c*ROT_W +: ROT_W];
            end
        end
    end

    always_comb begin
        w_rdy[3] = i_rdy;
        for (int k = 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) r_vld[0] <= i_vld;
            if (w_rdy[1]) r_vld[1] <= r_vld[0];
            if (w_rdy[2]) r_vld[2] <= r_vld[1];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 3; r++) begin
            if (w_rdy[0]) begin
                for (int c = 0; c < 3; c++) begin
                    r_prod[r][c] <= w_rot[r][c] * w_p[c];
                end
            end
            if (w_rdy[1]) begin
                r_sum[r] <= SUM_W'(r_prod[r][0]) + SUM_W'(r_prod[r][1])
                          + SUM_W'(r_prod[r][2]);
            end
            // arithmetic shift floors toward minus infinity
            if (w_rdy[2]) begin
                r_cam[r] <= CAM_W'($signed(r_sum[r][SUM_W-1:Q_FRAC])) + CAM_W'(w_t[r]);
            end
        end
    end

    assign o_rdy = w_rdy[0];
    assign o_vld = r_vld[2];
    assign o_xc  = r_cam[0];
    assign o_yc  = r_cam[1];
    assign o_zc  = r_cam[2];

endmodule

// ===== sv/ppp_persp.sv =====
module ppp_persp #(
    parameter int XC_W = 29
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [ppp_pkg::F_W-1:0]          i_focal,
    input  logic                             i_vld,
    output logic                             o_rdy,
    input  logic signed [XC_W-1:0]           i_xc,
    input  logic signed [XC_W-1:0]           i_yc,
    input  logic signed [XC_W-1:0]           i_zc,
    output logic                             o_vld,
    input  logic                             i_rdy,
    output logic signed [ppp_pkg::OUT_W-1:0] o_u,
    output logic signed [ppp_pkg::OUT_W-1:0] o_v,
    output logic                             o_dv
);
    import ppp_pkg::*;

    localparam int MAG_W = XC_W + F_W;
    localparam int PR_W  = MAG_W + 1;
    localparam logic [MAG_W-1:0] LIM_POS = MAG_W'(64'h7FFF_FFFF);
    localparam logic [MAG_W-1:0] LIM_NEG = MAG_W'(64'h8000_0000);

    logic r1_vld, r2_vld, r3_vld;
    logic w_rdy1, w_rdy2, w_rdy3;

    logic signed [PR_W-1:0] r1_nu, r1_nv;
    logic signed [XC_W-1:0] r1_zc;

    logic [1:0][MAG_W-1:0]  r2_mag;
    logic [XC_W-1:0]        r2_den;
    logic [2:0]             r2_sb;   // {sign u, sign v, zero depth}

    logic                   w_div_rdy, w_div_vld;
    logic [1:0][MAG_W-1:0]  w_quo;
    logic [1:0][XC_W-1:0]   w_rem;
    logic [2:0]             w_sb;
    logic [1:0][OUT_W-1:0]  w_sat;

    logic signed [OUT_W-1:0] r_u, r_v;
    logic                    r_dv;

    assign w_rdy3 = !r3_vld || i_rdy;
    assign w_rdy2 = !r2_vld || w_div_rdy;
    assign w_rdy1 = !r1_vld || w_rdy2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else begin
            if (w_rdy1) r1_vld <= i_vld;
            if (w_rdy2) r2_vld <= r1_vld;
            if (w_rdy3) r3_vld <= w_div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r1_nu <= i_xc * $signed({1'b0, i_focal});
            r1_nv <= i_yc * $signed({1'b0, i_focal});
            r1_zc <= i_zc;
        end
        if (w_rdy2) begin
            r2_mag[0] <= r1_nu[PR_W-1] ? MAG_W'(-r1_nu) : MAG_W'(r1_nu);
            r2_mag[1] <= r1_nv[PR_W-1] ? MAG_W'(-r1_nv) : MAG_W'(r1_nv);
            r2_den    <= r1_zc[XC_W-1] ? XC_W'(-r1_zc) : XC_W'(r1_zc);
            r2_sb     <= {r1_nu[PR_W-1] ^ r1_zc[XC_W-1],
                          r1_nv[PR_W-1] ^ r1_zc[XC_W-1],
                          r1_zc == '0};
        end
    end

    ppp_div #(
        .N_W   (MAG_W),
        .D_W   (XC_W),
        .LANES (2),
        .SB_W  (3)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r2_vld),
        .o_rdy   (w_div_rdy),
        .i_num   (r2_mag),
        .i_den   ({r2_den, r2_den}),
        .i_sb    (r2_sb),
        .o_vld   (w_div_vld),
        .i_rdy   (w_rdy3),
        .o_quo   (w_quo),
        .o_rem   (w_rem),
        .o_sb    (w_sb)
    );

    // sign back on and clamp to 32 bits; lane 0 is u, lane 1 is v
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            if (!w_sb[2-l]) begin
                w_sat[l] = (w_quo[l] > LIM_POS) ? 32'h7FFF_FFFF : w_quo[l][OUT_W-1:0];
            end else begin
                w_sat[l] = (w_quo[l] > LIM_NEG) ? 32'h8000_0000 : -w_quo[l][OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r_u  <= w_sb[0] ? '0 : $signed(w_sat[0]);
            r_v  <= w_sb[0] ? '0 : $signed(w_sat[1]);
            r_dv <= !w_sb[0];
        end
    end

    assign o_rdy = w_rdy1;
    assign o_vld = r3_vld;
    assign o_u   = r_u;
    assign o_v   = r_v;
    assign o_dv  = r_dv;

endmodule

// ===== sv/ppp_pixel.sv =====
module ppp_pixel #(
    parameter int DIM_W = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [2*ppp_pkg::PITCH_W-1:0]      i_pitch,
    input  logic [2*ppp_pkg::SIZE_W-1:0]       i_size,
    input  logic                               i_vld,
    output logic                               o_rdy,
    input  logic signed [ppp_pkg::OUT_W-1:0]   i_u,
    input  logic signed [ppp_pkg::OUT_W-1:0]   i_v,
    input  logic                               i_dv,
    output logic                               o_vld,
    input  logic                               i_rdy,
    output logic signed [ppp_pkg::OUT_W-1:0]   o_u,
    output logic signed [ppp_pkg::OUT_W-1:0]   o_v,
    output logic [DIM_W-1:0]                   o_col,
    output logic [DIM_W-1:0]                   o_row,
    output logic                               o_in,
    output logic                               o_dv
);
    import ppp_pkg::*;

    localparam int FQ_W  = OUT_W + 2;
    localparam int POS_W = FQ_W + 1;
    localparam int SB_W  = 2*OUT_W + 3;

    logic r1_vld, r2_vld, r3_vld;
    logic w_rdy1, w_rdy2, w_rdy3;

    logic [1:0][OUT_W-1:0] r1_mag;
    logic [SB_W-1:0]       r1_sb;   // {u, v, dv, sign u, sign v}

    logic                    w_div_rdy, w_div_vld;
    logic [1:0][OUT_W-1:0]   w_quo;
    logic [1:0][PITCH_W-1:0] w_rem;
    logic [SB_W-1:0]         w_sb;
    logic signed [FQ_W-1:0]  w_fq [2];

    logic signed [FQ_W-1:0]  r2_fq [2];
    logic signed [OUT_W-1:0] r2_u, r2_v;
    logic                    r2_dv;

    logic signed [POS_W-1:0] w_pos [2];
    logic [1:0]              w_ok;
    logic [SIZE_W-1:0]       w_dim [2];
    logic                    w_in;

    logic signed [OUT_W-1:0] r_u, r_v;
    logic [DIM_W-1:0]        r_col, r_row;
    logic                    r_in, r_dv;

    assign w_rdy3 = !r3_vld || i_rdy;
    assign w_rdy2 = !r2_vld || w_rdy3;
    assign w_rdy1 = !r1_vld || w_div_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else begin
            if (w_rdy1) r1_vld <= i_vld;
            if (w_rdy2) r2_vld <= w_div_vld;
            if (w_rdy3) r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r1_mag[0] <= i_u[OUT_W-1] ? OUT_W'(-i_u) : OUT_W'(i_u);
            r1_mag[1] <= i_v[OUT_W-1] ? OUT_W'(-i_v) : OUT_W'(i_v);
            r1_sb     <= {i_u, i_v, i_dv, i_u[OUT_W-1], i_v[OUT_W-1]};
        end
    end

    ppp_div #(
        .N_W   (OUT_W),
        .D_W   (PITCH_W),
        .LANES (2),
        .SB_W  (SB_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r1_vld),
        .o_rdy   (w_div_rdy),
        .i_num   (r1_mag),
        .i_den   ({i_pitch[2*PITCH_W-1:PITCH_W], i_pitch[PITCH_W-1:0]}),
        .i_sb    (r1_sb),
        .o_vld   (w_div_vld),
        .i_rdy   (w_rdy2),
        .o_quo   (w_quo),
        .o_rem   (w_rem),
        .o_sb    (w_sb)
    );

    // floor division: a negative dividend with a remainder rounds one further down
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            if (w_sb[1-l]) begin
                w_fq[l] = -$signed(FQ_W'(w_quo[l]) + FQ_W'(|w_rem[l]));
            end else begin
                w_fq[l] = $signed(FQ_W'(w_quo[l]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r2_fq[0] <= w_fq[0];
            r2_fq[1] <= w_fq[1];
            r2_u     <= $signed(w_sb[SB_W-1 -: OUT_W]);
            r2_v     <= $signed(w_sb[SB_W-OUT_W-1 -: OUT_W]);
            r2_dv    <= w_sb[2];
        end
    end

    always_comb begin
        w_dim[0] = i_size[SIZE_W-1:0];
        w_dim[1] = i_size[2*SIZE_W-1:SIZE_W];
        for (int l = 0; l < 2; l++) begin
            w_pos[l] = POS_W'(r2_fq[l]) + $signed(POS_W'(w_dim[l][SIZE_W-1:1]));
            w_ok[l]  = !w_pos[l][POS_W-1] && (w_pos[l] < $signed(POS_W'(w_dim[l])));
        end
        w_in = r2_dv && (i_pitch[PITCH_W-1:0] != '0)
             && (i_pitch[2*PITCH_W-1:PITCH_W] != '0) && (&w_ok);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r_u   <= r2_u;
            r_v   <= r2_v;
            r_col <= w_in ? w_pos[0][DIM_W-1:0] : '0;
            r_row <= w_in ? w_pos[1][DIM_W-1:0] : '0;
            r_in  <= w_in;
            r_dv  <= r2_dv;
        end
    end

    assign o_rdy = w_rdy1;
    assign o_vld = r3_vld;
    assign o_u   = r_u;
    assign o_v   = r_v;
    assign o_col = r_col;
    assign o_row = r_row;
    assign o_in  = r_in;
    assign o_dv  = r_dv;

endmodule

// ===== sv/pinhole_point_projector.sv =====
// Pinhole point projector.
// Input channel (i_in_valid / o_in_ready) takes one 3D point per beat; output
// channel (o_out_valid / i_out_ready) returns one result beat per point, in
// order: projected u, v on the image plane, pixel column/row, in-image and
// depth-valid flags.
// Config: write i_cfg_data to register i_cfg_index when i_cfg_we is high; only
// while no point is in flight. Unknown indexes are ignored.
// Throughput: one point per cycle while the output is not stalled. The pipe is
// built around the two bit-per-stage dividers: a POINT_BITS+25 stage one
// for the perspective divide and a 32 stage one for the pitch divide, plus
// 3 transform stages and 6 stages of prep and post processing.
// Every stage carries a valid bit and only holds when it is full and the stage
// ahead is stalled, so a stalled receiver fills the bubbles first; input ready
// drops only once the whole pipe is full.
// Reset (synchronous, active low) empties the pipe and loads the config
// registers with identity rotation, zero translation, 1000 mm focal length,
// 1 mm pitch and a 512 x 512 image.
module pinhole_point_projector #(
    parameter int POINT_BITS     = 24,
    parameter int IMAGE_DIM_BITS = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ppp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ppp_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [POINT_BITS-1:0]       i_point_x,
    input  logic signed [POINT_BITS-1:0]       i_point_y,
    input  logic signed [POINT_BITS-1:0]       i_point_z,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [ppp_pkg::OUT_W-1:0]   o_proj_u,
    output logic signed [ppp_pkg::OUT_W-1:0]   o_proj_v,
    output logic [IMAGE_DIM_BITS-1:0]          o_pixel_col,
    output logic [IMAGE_DIM_BITS-1:0]          o_pixel_row,
    output logic                               o_in_image,
    output logic                               o_depth_valid
);
    import ppp_pkg::*;

    localparam int XC_W = POINT_BITS + 5;

    t_cfg r_cfg;

    logic                   w_xf_vld, w_xf_rdy;
    logic signed [XC_W-1:0] w_xc, w_yc, w_zc;
    logic                   w_pr_vld, w_pr_rdy;
    logic signed [OUT_W-1:0] w_u, w_v;
    logic                   w_dv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rot[0] <= ROT0_RST;
            r_cfg.rot[1] <= ROT1_RST;
            r_cfg.rot[2] <= ROT2_RST;
            r_cfg.trans  <= TRANS_RST;
            r_cfg.focal  <= FOCAL_RST;
            r_cfg.pitch  <= PITCH_RST;
            r_cfg.size   <= SIZE_RST;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_ROT0:  r_cfg.rot[0] <= i_cfg_data[3*ROT_W-1:0];
                REG_ROT1:  r_cfg.rot[1] <= i_cfg_data[3*ROT_W-1:0];
                REG_ROT2:  r_cfg.rot[2] <= i_cfg_data[3*ROT_W-1:0];
                REG_TRANS: r_cfg.trans  <= i_cfg_data[3*T_W-1:0];
                REG_FOCAL: r_cfg.focal  <= i_cfg_data[F_W-1:0];
                REG_PITCH: r_cfg.pitch  <= i_cfg_data[2*PITCH_W-1:0];
                REG_SIZE:  r_cfg.size   <= i_cfg_data[2*SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    ppp_xform #(
        .P_W (POINT_BITS)
    ) u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_vld   (i_in_valid),
        .o_rdy   (o_in_ready),
        .i_px    (i_point_x),
        .i_py    (i_point_y),
        .i_pz    (i_point_z),
        .o_vld   (w_xf_vld),
        .i_rdy   (w_xf_rdy),
        .o_xc    (w_xc),
        .o_yc    (w_yc),
        .o_zc    (w_zc)
    );

    ppp_persp #(
        .XC_W (XC_W)
    ) u_persp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_focal (r_cfg.focal),
        .i_vld   (w_xf_vld),
        .o_rdy   (w_xf_rdy),
        .i_xc    (w_xc),
        .i_yc    (w_yc),
        .i_zc    (w_zc),
        .o_vld   (w_pr_vld),
        .i_rdy   (w_pr_rdy),
        .o_u     (w_u),
        .o_v     (w_v),
        .o_dv    (w_dv)
    );

    ppp_pixel #(
        .DIM_W (IMAGE_DIM_BITS)
    ) u_pixel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pitch (r_cfg.pitch),
        .i_size  (r_cfg.size),
        .i_vld   (w_pr_vld),
        .o_rdy   (w_pr_rdy),
        .i_u     (w_u),
        .i_v     (w_v),
        .i_dv    (w_dv),
        .o_vld   (o_out_valid),
        .i_rdy   (i_out_ready),
        .o_u     (o_proj_u),
        .o_v     (o_proj_v),
        .o_col   (o_pixel_col),
        .o_row   (o_pixel_row),
        .o_in    (o_in_image),
        .o_dv    (o_depth_valid)
    );

    a_zero_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_depth_valid |->
            o_proj_u == '0 && o_proj_v == '0 && !o_in_image)
        else $error("zero depth result carries nonzero fields");

    a_in_needs_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_in_image |-> o_depth_valid)
        else $error("in-image flag without valid depth");

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_in_image |-> o_pixel_col == '0 && o_pixel_row == '0)
        else $error("pixel outside image not cleared");

endmodule
